// ===== design/shfr_pkg.sv =====
// Shared types and constants for the sync-header frame receiver.
// No dependencies; used by sync_header_frame_receiver and shfr_checker.
package shfr_pkg;

    localparam int unsigned IDX_W  = 9;   // store index width
    localparam int unsigned CNT_W  = 3;   // sync counter width
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [7:0]       SYNC_BYTE  = 8'h50;
    localparam logic [IDX_W-1:0] LEN_POS    = 9'd7;
    localparam logic [IDX_W-1:0] CMD_HI_POS = 9'd12;
    localparam logic [IDX_W-1:0] CMD_LO_POS = 9'd13;
    localparam logic [IDX_W-1:0] HDR_BYTES  = 9'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_CODE  = 2'd0,
        CFG_DISABLE_CODE = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic        frame_done;
        logic        frame_dropped;
        logic [15:0] command;
        logic        host_control;
        logic        in_frame;
    } result_t;

endpackage

// ===== design/sync_header_frame_receiver.sv =====
// Top level of the sync-header frame receiver: input register, per-byte
// deframing logic and result register. Depends on shfr_pkg.

// Byte-serial deframer. Each accepted word is one received byte and yields
// exactly one result word. While hunting, SYNC_COUNT consecutive 0x50 bytes
// open a frame; inside a frame byte 7 is the payload length and the frame
// closes once length+12 bytes (sync bytes included) have been counted. At a
// good close, bytes 12 and 13 form a big-endian command that is compared with
// enable_code and disable_code (disable wins if both match) to set or clear
// host_control. A zero length, or an index reaching MAX_FRAME_LEN, drops the
// frame. Throughput is one byte per clock while the output is not stalled: a
// byte is captured in the input register, then the frame state is updated
// and the result loaded into the output register that drives out_valid.
// in_stall rises only when both registers are full and the output is
// stalled. cfg_ready is always high; write codes only while idle.
module sync_header_frame_receiver #(
    parameter int unsigned MAX_FRAME_LEN = 256,   // 16..512
    parameter int unsigned SYNC_COUNT    = 4      // 1..7
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [shfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_done,
    output logic        frame_dropped,
    output logic [15:0] command,
    output logic        host_control,
    output logic        in_frame
);

    localparam logic [shfr_pkg::IDX_W:0] MAX_LEN =
        (shfr_pkg::IDX_W+1)'(MAX_FRAME_LEN);
    localparam logic [shfr_pkg::CNT_W-1:0] SYNC_N =
        shfr_pkg::CNT_W'(SYNC_COUNT);

    // config registers
    logic [15:0] enable_code_reg;
    logic [15:0] disable_code_reg;

    // pipeline registers
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s2_valid_reg;
    shfr_pkg::result_t s2_result_reg;
    shfr_pkg::result_t s2_result_next;

    // frame state
    logic                          in_frame_reg,  in_frame_next;
    logic [shfr_pkg::CNT_W-1:0]    sync_cnt_reg,  sync_cnt_next;
    logic [shfr_pkg::IDX_W-1:0]    wr_idx_reg,    wr_idx_next;
    logic [7:0]                    len_reg,       len_next;
    logic [7:0]                    cmd_hi_reg,    cmd_hi_next;
    logic [7:0]                    cmd_lo_reg,    cmd_lo_next;
    logic [15:0]                   last_cmd_reg,  last_cmd_next;
    logic                          host_ctrl_reg, host_ctrl_next;

    logic s2_load;     // s1 word moves into the result register
    logic s1_load;     // input word accepted

    logic [shfr_pkg::IDX_W:0] idx_inc;
    logic [shfr_pkg::IDX_W:0] frame_end;
    logic [15:0]              cmd_word;
    logic                     done, dropped;

    assign cfg_ready = 1'b1;

    // handshake: the result register drains or is empty, then s1 can move on
    assign s2_load  = s1_valid_reg && !(s2_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_code_reg  <= '0;
            disable_code_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                shfr_pkg::CFG_ENABLE_CODE:  enable_code_reg  <= cfg_data;
                shfr_pkg::CFG_DISABLE_CODE: disable_code_reg <= cfg_data;
                default: ;   // unused index, ignored
            endcase
        end
    end

    // per-byte deframing
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        sync_cnt_next  = sync_cnt_reg;
        wr_idx_next    = wr_idx_reg;
        len_next       = len_reg;
        cmd_hi_next    = cmd_hi_reg;
        cmd_lo_next    = cmd_lo_reg;
        last_cmd_next  = last_cmd_reg;
        host_ctrl_next = host_ctrl_reg;
        done           = 1'b0;
        dropped        = 1'b0;
        idx_inc        = {1'b0, wr_idx_reg} + 1'b1;
        cmd_word       = '0;

        // store taps, only when the byte is actually stored
        if (in_frame_reg || s1_byte_reg == shfr_pkg::SYNC_BYTE)
        begin
            if (wr_idx_reg == shfr_pkg::LEN_POS)    len_next    = s1_byte_reg;
            if (wr_idx_reg == shfr_pkg::CMD_HI_POS) cmd_hi_next = s1_byte_reg;
            if (wr_idx_reg == shfr_pkg::CMD_LO_POS) cmd_lo_next = s1_byte_reg;
        end

        // end compare uses the length as just stored
        frame_end = {1'b0, shfr_pkg::HDR_BYTES} + {2'b0, len_next};

        if (!in_frame_reg)
        begin
            if (s1_byte_reg == shfr_pkg::SYNC_BYTE)
            begin
                wr_idx_next   = idx_inc[shfr_pkg::IDX_W-1:0];
                sync_cnt_next = sync_cnt_reg + 1'b1;
                if (sync_cnt_next >= SYNC_N)
                begin
                    sync_cnt_next = '0;
                    in_frame_next = 1'b1;
                end
            end
            else
            begin
                sync_cnt_next = '0;
                wr_idx_next   = '0;
            end
        end
        else if (idx_inc >= MAX_LEN)
        begin
            // overflow abort
            dropped       = 1'b1;
            wr_idx_next   = '0;
            sync_cnt_next = '0;
            in_frame_next = 1'b0;
        end
        else
        begin
            wr_idx_next = idx_inc[shfr_pkg::IDX_W-1:0];
            if (idx_inc == frame_end)
            begin
                if (len_next == 8'd0)
                    dropped = 1'b1;
                else
                begin
                    done          = 1'b1;
                    cmd_word      = {cmd_hi_next, cmd_lo_next};
                    last_cmd_next = cmd_word;
                    if (cmd_word == enable_code_reg)  host_ctrl_next = 1'b1;
                    if (cmd_word == disable_code_reg) host_ctrl_next = 1'b0;
                end
                wr_idx_next   = '0;
                sync_cnt_next = '0;
                in_frame_next = 1'b0;
            end
        end

        s2_result_next.frame_done    = done;
        s2_result_next.frame_dropped = dropped;
        s2_result_next.command       = last_cmd_next;
        s2_result_next.host_control  = host_ctrl_next;
        s2_result_next.in_frame      = in_frame_next;
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            in_frame_reg  <= 1'b0;
            sync_cnt_reg  <= '0;
            wr_idx_reg    <= '0;
            len_reg       <= '0;
            cmd_hi_reg    <= '0;
            cmd_lo_reg    <= '0;
            last_cmd_reg  <= '0;
            host_ctrl_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;

            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (!out_stall)
                s2_valid_reg <= 1'b0;

            if (s2_load)
            begin
                in_frame_reg  <= in_frame_next;
                sync_cnt_reg  <= sync_cnt_next;
                wr_idx_reg    <= wr_idx_next;
                len_reg       <= len_next;
                cmd_hi_reg    <= cmd_hi_next;
                cmd_lo_reg    <= cmd_lo_next;
                last_cmd_reg  <= last_cmd_next;
                host_ctrl_reg <= host_ctrl_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_byte_reg <= rx_byte;
        if (s2_load)
            s2_result_reg <= s2_result_next;
    end

    assign out_valid     = s2_valid_reg;
    assign frame_done    = s2_result_reg.frame_done;
    assign frame_dropped = s2_result_reg.frame_dropped;
    assign command       = s2_result_reg.command;
    assign host_control  = s2_result_reg.host_control;
    assign in_frame      = s2_result_reg.in_frame;

endmodule

// ===== design/shfr_checker.sv =====
// Port-level checks for sync_header_frame_receiver, attached by bind.
// Depends only on the top level's ports.
module shfr_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        frame_done,
    input logic        frame_dropped,
    input logic [15:0] command,
    input logic        in_frame
);

    // a closed or dropped frame leaves the block hunting
    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_done || frame_dropped) |-> !in_frame)
        else $error("frame end with in_frame still set");

    a_done_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_done && frame_dropped))
        else $error("frame both done and dropped");

    // input backs up only behind a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without stalled output word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command))
        else $error("stalled output word changed");

endmodule

bind sync_header_frame_receiver shfr_port_checks u_shfr_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_done    (frame_done),
    .frame_dropped (frame_dropped),
    .command       (command),
    .in_frame      (in_frame)
);

// ===== bench/shfr_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the sync-header frame receiver: keeps its own copy of the
// deframing state, predicts one result word per accepted byte and compares.
// Depends on shfr_pkg.
module shfr_checker #(
    parameter int unsigned MAX_FRAME_LEN = 256,
    parameter int unsigned SYNC_COUNT    = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [shfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           frame_done,
    input  logic                           frame_dropped,
    input  logic [15:0]                    command,
    input  logic                           host_control,
    input  logic                           in_frame,
    output int                             fail_count,
    output int                             pending_words
);

    logic [15:0]                on_code, off_code;
    logic                       framing;
    logic [shfr_pkg::CNT_W-1:0] syncs_seen;
    logic [shfr_pkg::IDX_W-1:0] byte_pos;
    logic [7:0]                 len_field, cmd_hi, cmd_lo;
    logic [15:0]                cmd_word;
    logic                       host_flag;

    shfr_pkg::result_t words_due[$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    // header fields are latched whenever their position is written
    task automatic capture_fields(input logic [7:0] b);
        if (byte_pos == shfr_pkg::LEN_POS)
            len_field = b;
        if (byte_pos == shfr_pkg::CMD_HI_POS)
            cmd_hi = b;
        if (byte_pos == shfr_pkg::CMD_LO_POS)
            cmd_lo = b;
    endtask

    task automatic rehunt();
        byte_pos   = '0;
        syncs_seen = '0;
        framing    = 1'b0;
    endtask

    task automatic deframe(input logic [7:0] b, output shfr_pkg::result_t r);
        int unsigned nxt;
        r = '0;
        if (!framing)
        begin
            if (b == shfr_pkg::SYNC_BYTE)
            begin
                capture_fields(b);
                byte_pos   = byte_pos + 1'b1;
                syncs_seen = syncs_seen + 1'b1;
                if (syncs_seen >= SYNC_COUNT)
                begin
                    syncs_seen = '0;
                    framing    = 1'b1;
                end
            end
            else
            begin
                syncs_seen = '0;
                byte_pos   = '0;
            end
        end
        else
        begin
            capture_fields(b);
            nxt = int'(byte_pos) + 1;
            if (nxt >= MAX_FRAME_LEN)
            begin
                rehunt();
                r.frame_dropped = 1'b1;
            end
            else
            begin
                byte_pos = nxt[shfr_pkg::IDX_W-1:0];
                if (nxt == int'(len_field) + int'(shfr_pkg::HDR_BYTES))
                begin
                    if (len_field == 8'd0)
                        r.frame_dropped = 1'b1;
                    else
                    begin
                        r.frame_done = 1'b1;
                        cmd_word = {cmd_hi, cmd_lo};
                        // disable is tested last, so it wins on equal codes
                        if (cmd_word == on_code)
                            host_flag = 1'b1;
                        if (cmd_word == off_code)
                            host_flag = 1'b0;
                    end
                    rehunt();
                end
            end
        end
        r.command      = cmd_word;
        r.host_control = host_flag;
        r.in_frame     = framing;
    endtask

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        shfr_pkg::result_t due, fresh;
        if (!rst_n)
        begin
            on_code    = '0;
            off_code   = '0;
            framing    = 1'b0;
            syncs_seen = '0;
            byte_pos   = '0;
            len_field  = '0;
            cmd_hi     = '0;
            cmd_lo     = '0;
            cmd_word   = '0;
            host_flag  = 1'b0;
            words_due.delete();
            pending_words <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    shfr_pkg::CFG_ENABLE_CODE:  on_code  = cfg_data;
                    shfr_pkg::CFG_DISABLE_CODE: off_code = cfg_data;
                    default: ;
                endcase
            if (out_valid && !out_stall)
            begin
                if (words_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word, expected none actual %0h",
                             $time, {frame_done, frame_dropped, command,
                                     host_control, in_frame});
                end
                else
                begin
                    due = words_due.pop_front();
                    compare_field("frame_done", 16'(due.frame_done), 16'(frame_done));
                    compare_field("frame_dropped", 16'(due.frame_dropped),
                                  16'(frame_dropped));
                    compare_field("command", due.command, command);
                    compare_field("host_control", 16'(due.host_control),
                                  16'(host_control));
                    compare_field("in_frame", 16'(due.in_frame), 16'(in_frame));
                end
            end
            if (in_valid && !in_stall)
            begin
                deframe(rx_byte, fresh);
                words_due.push_back(fresh);
            end
            pending_words <= words_due.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for sync_header_frame_receiver: drives bytes and code writes,
// stalls the result side, and reports the verdict from shfr_checker.
// Depends on shfr_pkg, sync_header_frame_receiver and shfr_checker.
module tb;

    localparam int unsigned FRAME_LIMIT  = 256;
    localparam int unsigned SYNC_RUN     = 4;
    localparam int unsigned PHASES       = 5;
    localparam int unsigned PHASE_BYTES  = 100;   // random bytes per code setting
    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no word moving
    localparam int unsigned LONG_HOLD    = 64;    // one long result-side stall
    localparam int unsigned HOLD_AT      = 300;   // ... after this many results
    // index that no register decodes; writes to it must be ignored
    localparam logic [shfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [shfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                    cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic [7:0]                     rx_byte   = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_ready, in_stall, out_valid;
    logic                           frame_done, frame_dropped, host_control, in_frame;
    logic [15:0]                    command;
    int                             fail_count, pending_words;

    int unsigned max_gap = 5;      // idle draw range for both sides
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned code_sets = 0;
    int unsigned idle_cycles = 0;
    logic [15:0] en_code, dis_code;

    sync_header_frame_receiver #(
        .MAX_FRAME_LEN (FRAME_LIMIT),
        .SYNC_COUNT    (SYNC_RUN)
    ) uut (.*);

    shfr_checker #(
        .MAX_FRAME_LEN (FRAME_LIMIT),
        .SYNC_COUNT    (SYNC_RUN)
    ) u_checker (.*);

    always #1 clk = ~clk;

    // Watchdog: any word moving on any channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: random stall before each word, plus one long hold so the
    // pipeline fills and the input stalls while bytes keep being offered.
    initial
    begin : result_sink
        int unsigned hold, taken;
        taken = 0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            hold = (taken == HOLD_AT) ? LONG_HOLD : $urandom_range(0, max_gap);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            taken++;
        end
    end

    // Offer one byte after a random gap; returns on the accepting edge with
    // valid still high, so back-to-back bytes never toggle it.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    function automatic logic [7:0] not_sync();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == shfr_pkg::SYNC_BYTE) ? ~b : b;
    endfunction

    // Sync run, header with length at byte 7, command at bytes 12/13.
    // keep != 0 cuts the frame short (broken sequence).
    task automatic send_frame(input logic [7:0] len, input logic [15:0] cmd,
                              input int unsigned keep);
        int unsigned span, pos;
        span = int'(len) + int'(shfr_pkg::HDR_BYTES);
        if (span > FRAME_LIMIT)
            span = FRAME_LIMIT;
        if (keep != 0 && keep < span)
            span = keep;
        for (pos = 0; pos < span; pos++)
        begin
            if (pos < SYNC_RUN)
                send_byte(shfr_pkg::SYNC_BYTE);
            else if (pos == shfr_pkg::LEN_POS)
                send_byte(len);
            else if (pos == shfr_pkg::CMD_HI_POS)
                send_byte(cmd[15:8]);
            else if (pos == shfr_pkg::CMD_LO_POS)
                send_byte(cmd[7:0]);
            else
                send_byte(8'($urandom));
        end
        frames_sent++;
    endtask

    // Mostly short payloads; a few zero-length and a few near or past the limit.
    function automatic logic [7:0] frame_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'd0;
        if (r < 7)
            return 8'($urandom_range(200, 255));
        return 8'($urandom_range(1, 24));
    endfunction

    function automatic logic [15:0] pick_cmd();
        case ($urandom_range(0, 3))
            0:       return en_code;
            1:       return dis_code;
            2:       return en_code ^ (16'd1 << $urandom_range(0, 15));  // near miss
            default: return 16'($urandom);
        endcase
    endfunction

    // Leaves cfg_valid high between back-to-back writes; caller lowers it.
    task automatic write_reg(input logic [shfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_codes(input logic [15:0] en, input logic [15:0] dis,
                             input bit spare);
        en_code  = en;
        dis_code = dis;
        write_reg(shfr_pkg::CFG_ENABLE_CODE, en);
        write_reg(shfr_pkg::CFG_DISABLE_CODE, dis);
        if (spare)
            write_reg(CFG_SPARE_IDX, 16'($urandom));
        cfg_valid <= 1'b0;
        code_sets++;
    endtask

    // Sender pause: no bytes until every expected result word has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    initial
    begin : stimulus
        int unsigned phase, phase_end, n;
        logic [15:0] v;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Enable code matches a length-1 frame whose low
        // command byte is still the zero left by reset.
        set_codes(16'hA500, 16'hFFFF, 1'b0);
        // partial sync broken by a non-sync byte, plus byte extremes
        send_byte(shfr_pkg::SYNC_BYTE);
        send_byte(shfr_pkg::SYNC_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        // short frame: ends before byte 13, command takes the stale low byte
        send_frame(8'd1, 16'hA5FF, 0);
        // zero length: dropped at byte 11
        send_frame(8'd0, 16'($urandom), 0);
        // index overflow: length 255 runs into the frame limit
        send_frame(8'd255, 16'($urandom), 0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0: set_codes(16'h0000, 16'hFFFF, 1'b0);
                1: set_codes(16'hFFFF, 16'h0000, 1'b0);
                2:
                begin
                    // equal codes: disable must win
                    v = 16'($urandom);
                    set_codes(v, v, 1'b0);
                end
                default: set_codes(16'($urandom), 16'($urandom), phase == 3);
            endcase
            // one stretch with no idling on either side
            max_gap = (phase == 3) ? 0 : 5;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                case ($urandom_range(0, 9))
                    7:
                    begin
                        // noise, sync-heavy, closed by a non-sync byte
                        n = $urandom_range(1, 8);
                        repeat (n)
                            send_byte($urandom_range(0, 1) ? shfr_pkg::SYNC_BYTE
                                                           : 8'($urandom));
                        send_byte(not_sync());
                    end
                    8:
                    begin
                        n = $urandom_range(1, SYNC_RUN - 1);
                        repeat (n) send_byte(shfr_pkg::SYNC_BYTE);
                        send_byte(not_sync());
                    end
                    9: send_frame(frame_len(), pick_cmd(), $urandom_range(5, 15));
                    default: send_frame(frame_len(), pick_cmd(), 0);
                endcase
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d bytes in %0d frames over %0d code settings,",
                 bytes_sent, frames_sent, code_sets);
        $display("including short, zero-length, overflow and broken frames.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/shfr_pkg.sv
design/sync_header_frame_receiver.sv
design/shfr_checker.sv
bench/shfr_checker.sv
bench/tb.sv
